/* design/nrf_pkg.sv */
// Shared constants, types and codes of the nonce replay filter.
package nrf_pkg;

    localparam int PEERS  = 4;
    localparam int WINDOW = 4096;

    localparam int PEER_W   = $clog2(PEERS);
    localparam int PEERC_W  = $clog2(PEERS + 1);
    localparam int WIN_W    = $clog2(WINDOW);
    localparam int FILL_W   = $clog2(WINDOW + 1);
    localparam int DEPTH    = PEERS * WINDOW;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int ID_W     = 64;

    localparam logic [15:0] MIN_LEN = 16'd5;
    localparam int MIX_SHIFT = 33;
    localparam logic [63:0] MUL_A = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MUL_B = 64'hc4ceb9fe1a85ec53;

    typedef enum logic [2:0] {
        V_ACCEPT   = 3'd0,
        V_SHORT    = 3'd1,
        V_UNKNOWN  = 3'd2,
        V_BADNONCE = 3'd3,
        V_REPLAY   = 3'd4,
        V_AUTHFAIL = 3'd5,
        V_CLEARED  = 3'd6
    } verdict_t;

endpackage

/* design/nrf_if.sv */
// Request and response channel interfaces of the nonce replay filter.
interface nrf_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  peer;
    logic [15:0] packet_len;
    logic        peer_known;
    logic        nonce_ok;
    logic [31:0] nonce_prefix;
    logic [63:0] nonce_counter;
    logic        auth_ok;

    modport source (output valid, kind, peer, packet_len, peer_known, nonce_ok,
                    nonce_prefix, nonce_counter, auth_ok, input ready);
    modport sink (input valid, kind, peer, packet_len, peer_known, nonce_ok,
                  nonce_prefix, nonce_counter, auth_ok, output ready);
endinterface

interface nrf_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [63:0] packet_id;

    modport source (output valid, verdict, packet_id, input ready);
    modport sink (input valid, verdict, packet_id, output ready);
endinterface

/* design/nrf_ram.sv */
// Generic single-port RAM with registered read.
module nrf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end
endmodule

/* design/nrf_mix.sv */
// 64-bit avalanche finalizer on one shared 32x32 multiplier.
module nrf_mix (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] x,
    output logic        done,
    output logic [63:0] id
);
    typedef enum logic {ST_IDLE, ST_MUL} state_t;

    state_t      state_reg;
    logic [1:0]  part_reg;
    logic        sel_b_reg;
    logic [63:0] v_reg;
    logic [63:0] acc_reg;
    logic        done_reg;
    logic [63:0] id_reg;

    logic [63:0] cst;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod;
    logic [63:0] sum;
    logic [63:0] mixed;

    // low 64 bits of v*c: lo*clo + ((lo*chi + hi*clo) << 32)
    always_comb
    begin
        cst   = sel_b_reg ? nrf_pkg::MUL_B : nrf_pkg::MUL_A;
        op_a  = (part_reg == 2'd2) ? v_reg[63:32] : v_reg[31:0];
        op_b  = (part_reg == 2'd1) ? cst[63:32] : cst[31:0];
        prod  = 64'(op_a) * 64'(op_b);
        sum   = acc_reg + {prod[31:0], 32'd0};
        mixed = sum ^ (sum >> nrf_pkg::MIX_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            part_reg  <= 2'd0;
            sel_b_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        v_reg     <= x ^ (x >> nrf_pkg::MIX_SHIFT);
                        part_reg  <= 2'd0;
                        sel_b_reg <= 1'b0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    priority case (part_reg)
                        2'd0:
                        begin
                            acc_reg  <= prod;
                            part_reg <= 2'd1;
                        end
                        2'd1:
                        begin
                            acc_reg  <= sum;
                            part_reg <= 2'd2;
                        end
                        default:
                        begin
                            part_reg <= 2'd0;
                            if (!sel_b_reg)
                            begin
                                v_reg     <= mixed;
                                sel_b_reg <= 1'b1;
                            end
                            else
                            begin
                                id_reg    <= mixed;
                                done_reg  <= 1'b1;
                                state_reg <= ST_IDLE;
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    assign done = done_reg;
    assign id   = id_reg;

    a_part_range: assert property (@(posedge clk) disable iff (!rst_n)
        part_reg != 2'd3) else $error("mixer part out of range");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == ST_IDLE) else $error("done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> state_reg == ST_MUL)
        else $error("start not taken");
endmodule

/* design/nonce_replay_filter.sv */
// Top level of the nonce replay filter: control, per-peer window state, ID store.
//
//  channel | dir | payload
//  req     | in  | kind, peer, packet_len, peer_known, nonce_ok, nonce_prefix,
//          |     | nonce_counter, auth_ok
//  rsp     | out | verdict, packet_id
//
// One request at a time. Clear and early rejects go straight to the output
// stage; a checked packet first passes through the mixer, then its window
// entries, if any, are read one entry per cycle through the single read port
// of the ID store.
// Reset clears the head and fill counts but not the store; the store needs no clearing pass.
// A finished response waits in the output register; a new request is taken
// meanwhile, and a second result stalls until the first is taken.
module nonce_replay_filter (
    input  logic clk,
    input  logic rst_n,
    nrf_req_if.sink   req,
    nrf_rsp_if.source rsp
);
    typedef enum logic [2:0] {ST_IDLE, ST_MIX, ST_SCAN, ST_DECIDE, ST_EMIT} state_t;

    state_t                          state_reg;
    logic [nrf_pkg::PEER_W-1:0]      peer_reg;
    logic                            auth_reg;
    logic [2:0]                      verdict_reg;
    logic [63:0]                     id_reg;
    logic                            hit_reg;
    logic [nrf_pkg::FILL_W-1:0]      iss_reg;
    logic [nrf_pkg::FILL_W-1:0]      cmp_reg;
    logic                            pend_reg;
    logic [nrf_pkg::WIN_W-1:0]       head_reg [nrf_pkg::PEERS];
    logic [nrf_pkg::FILL_W-1:0]      fill_reg [nrf_pkg::PEERS];
    logic                            out_valid_reg;
    logic [2:0]                      out_verdict_reg;
    logic [63:0]                     out_id_reg;

    logic                            mix_start;
    logic                            mix_done;
    logic [63:0]                     mix_id;
    logic                            ram_en;
    logic                            ram_we;
    logic [nrf_pkg::ADDR_W-1:0]      ram_addr;
    logic [63:0]                     ram_rdata;
    logic [nrf_pkg::WIN_W-1:0]       cur_head;
    logic [nrf_pkg::FILL_W-1:0]      cur_fill;
    logic                            rd_issue;
    logic                            full;
    logic [nrf_pkg::WIN_W-1:0]       slot;
    logic                            req_fire;
    logic                            req_peer_ok;

    assign req_fire    = req.valid && req.ready;
    assign req.ready   = (state_reg == ST_IDLE);
    assign req_peer_ok = {1'b0, req.peer} < nrf_pkg::PEERC_W'(nrf_pkg::PEERS);
    assign cur_head    = head_reg[peer_reg];
    assign cur_fill    = fill_reg[peer_reg];
    assign full        = cur_fill >= nrf_pkg::FILL_W'(nrf_pkg::WINDOW);
    assign mix_start   = req_fire && !req.kind && req.packet_len >= nrf_pkg::MIN_LEN
                         && req.peer_known && req_peer_ok && req.nonce_ok;
    assign rd_issue    = (state_reg == ST_SCAN) && (iss_reg < cur_fill) && !hit_reg;

    always_comb
    begin
        ram_en = 1'b0;
        ram_we = 1'b0;
        slot   = cur_head + iss_reg[nrf_pkg::WIN_W-1:0];
        if (rd_issue)
            ram_en = 1'b1;
        else if (state_reg == ST_DECIDE && !hit_reg && auth_reg)
        begin
            ram_en = 1'b1;
            ram_we = 1'b1;
            slot   = full ? cur_head : cur_head + cur_fill[nrf_pkg::WIN_W-1:0];
        end
        ram_addr = {peer_reg, slot};
    end

    nrf_mix u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mix_start),
        .x     ({req.nonce_prefix, 32'd0} ^ req.nonce_counter),
        .done  (mix_done),
        .id    (mix_id)
    );

    nrf_ram #(
        .WIDTH (nrf_pkg::ID_W),
        .DEPTH (nrf_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (id_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            peer_reg      <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            for (int p = 0; p < nrf_pkg::PEERS; p++)
            begin
                head_reg[p] <= '0;
                fill_reg[p] <= '0;
            end
        end
        else
        begin
            // in ST_EMIT the output register is reloaded or still waiting
            if (rsp.valid && rsp.ready && state_reg != ST_EMIT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        peer_reg  <= req.peer;
                        auth_reg  <= req.auth_ok;
                        id_reg    <= '0;
                        state_reg <= ST_EMIT;
                        if (req.kind)
                        begin
                            verdict_reg <= nrf_pkg::V_CLEARED;
                            if (req_peer_ok)
                            begin
                                head_reg[req.peer] <= '0;
                                fill_reg[req.peer] <= '0;
                            end
                        end
                        else if (req.packet_len < nrf_pkg::MIN_LEN)
                            verdict_reg <= nrf_pkg::V_SHORT;
                        else if (!req.peer_known || !req_peer_ok)
                            verdict_reg <= nrf_pkg::V_UNKNOWN;
                        else if (!req.nonce_ok)
                            verdict_reg <= nrf_pkg::V_BADNONCE;
                        else
                            state_reg <= ST_MIX;
                    end
                end
                ST_MIX:
                begin
                    if (mix_done)
                    begin
                        id_reg    <= mix_id;
                        iss_reg   <= '0;
                        cmp_reg   <= '0;
                        pend_reg  <= 1'b0;
                        hit_reg   <= 1'b0;
                        state_reg <= (cur_fill == '0) ? ST_DECIDE : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    pend_reg <= rd_issue;
                    if (rd_issue)
                        iss_reg <= iss_reg + 1'b1;
                    if (pend_reg)
                    begin
                        if (ram_rdata == id_reg)
                        begin
                            hit_reg   <= 1'b1;
                            state_reg <= ST_DECIDE;
                        end
                        else
                        begin
                            cmp_reg <= cmp_reg + 1'b1;
                            if (cmp_reg + 1'b1 == cur_fill)
                                state_reg <= ST_DECIDE;
                        end
                    end
                end
                ST_DECIDE:
                begin
                    pend_reg  <= 1'b0;
                    state_reg <= ST_EMIT;
                    if (hit_reg)
                        verdict_reg <= nrf_pkg::V_REPLAY;
                    else if (!auth_reg)
                        verdict_reg <= nrf_pkg::V_AUTHFAIL;
                    else
                    begin
                        verdict_reg <= nrf_pkg::V_ACCEPT;
                        if (full)
                            head_reg[peer_reg] <= cur_head + 1'b1;
                        else
                            fill_reg[peer_reg] <= cur_fill + 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_verdict_reg <= verdict_reg;
                        out_id_reg      <= id_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.verdict   = out_verdict_reg;
    assign rsp.packet_id = out_id_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg[peer_reg] <= nrf_pkg::FILL_W'(nrf_pkg::WINDOW))
        else $error("window fill over capacity");
    a_mix_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mix_done |-> state_reg == ST_MIX) else $error("mixer result unexpected");
    a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg != ST_IDLE) else $error("request not taken");
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> !ram_we) else $error("store write during search");
endmodule

/* tb/nrf_tb_if.sv */
// Testbench types: request descriptor and expected response record.
`timescale 1ns / 1ps
package nrf_tb_pkg;

    typedef struct packed {
        logic        kind;
        logic [1:0]  peer;
        logic [15:0] packet_len;
        logic        peer_known;
        logic        nonce_ok;
        logic [31:0] nonce_prefix;
        logic [63:0] nonce_counter;
        logic        auth_ok;
    } pkt_desc_t;

    typedef struct packed {
        nrf_pkg::verdict_t verdict;
        logic [63:0]       packet_id;
    } verdict_rec_t;
endpackage

/* tb/nonce_replay_filter_tb.sv */
// Testbench for the nonce replay filter: directed table, a peer 1 replay run, then random packet streams.
`timescale 1ns / 1ps
module nonce_replay_filter_tb;
    localparam int N_RANDOM = 786;

    typedef struct {
        nrf_tb_pkg::pkt_desc_t    d;
        bit                       typed;
        nrf_tb_pkg::verdict_rec_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    nrf_req_if req ();
    nrf_rsp_if rsp ();

    nonce_replay_filter dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    always #5 clk = ~clk;

    // predictor state
    logic [63:0] win_ids [nrf_pkg::PEERS][nrf_pkg::WINDOW];
    int          win_head [nrf_pkg::PEERS];
    int          win_fill [nrf_pkg::PEERS];

    nrf_tb_pkg::verdict_rec_t pending_verdicts[$];
    stim_row_t rows[$];
    int  mismatches = 0;
    bit  failed = 1'b0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 1'b0;

    // nonces of recent well-formed, authenticated requests, replayed on purpose
    logic [31:0] used_prefix[$];
    logic [63:0] used_counter[$];
    logic [1:0]  used_peer[$];

    function automatic logic [63:0] mix_nonce(logic [31:0] pfx, logic [63:0] ctr);
        logic [63:0] x;
        x = {pfx, 32'd0} ^ ctr;
        x = x ^ (x >> nrf_pkg::MIX_SHIFT);
        x = x * nrf_pkg::MUL_A;
        x = x ^ (x >> nrf_pkg::MIX_SHIFT);
        x = x * nrf_pkg::MUL_B;
        x = x ^ (x >> nrf_pkg::MIX_SHIFT);
        return x;
    endfunction

    function automatic nrf_tb_pkg::verdict_rec_t filter_packet(nrf_tb_pkg::pkt_desc_t d);
        nrf_tb_pkg::verdict_rec_t r;
        int p;
        bit seen;
        p = d.peer;
        r.packet_id = '0;
        seen = 1'b0;
        if (d.kind)
        begin
            if (p < nrf_pkg::PEERS)
            begin
                win_head[p] = 0;
                win_fill[p] = 0;
            end
            r.verdict = nrf_pkg::V_CLEARED;
        end
        else if (d.packet_len < nrf_pkg::MIN_LEN)
        begin
            r.verdict = nrf_pkg::V_SHORT;
        end
        else if (!d.peer_known || p >= nrf_pkg::PEERS)
        begin
            r.verdict = nrf_pkg::V_UNKNOWN;
        end
        else if (!d.nonce_ok)
        begin
            r.verdict = nrf_pkg::V_BADNONCE;
        end
        else
        begin
            r.packet_id = mix_nonce(d.nonce_prefix, d.nonce_counter);
            for (int i = 0; i < win_fill[p]; i++)
                if (win_ids[p][(win_head[p] + i) % nrf_pkg::WINDOW] == r.packet_id)
                    seen = 1'b1;
            if (seen)
            begin
                r.verdict = nrf_pkg::V_REPLAY;
            end
            else if (!d.auth_ok)
            begin
                r.verdict = nrf_pkg::V_AUTHFAIL;
            end
            else
            begin
                if (win_fill[p] < nrf_pkg::WINDOW)
                begin
                    win_ids[p][(win_head[p] + win_fill[p]) % nrf_pkg::WINDOW] = r.packet_id;
                    win_fill[p]++;
                end
                else
                begin
                    win_ids[p][win_head[p]] = r.packet_id;
                    win_head[p] = (win_head[p] + 1) % nrf_pkg::WINDOW;
                end
                r.verdict = nrf_pkg::V_ACCEPT;
            end
        end
        return r;
    endfunction

    task automatic send_request(nrf_tb_pkg::pkt_desc_t d);
        nrf_tb_pkg::verdict_rec_t r;
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        req.valid         <= 1'b1;
        req.kind          <= d.kind;
        req.peer          <= d.peer;
        req.packet_len    <= d.packet_len;
        req.peer_known    <= d.peer_known;
        req.nonce_ok      <= d.nonce_ok;
        req.nonce_prefix  <= d.nonce_prefix;
        req.nonce_counter <= d.nonce_counter;
        req.auth_ok       <= d.auth_ok;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        r = filter_packet(d);
        pending_verdicts.insert(pending_verdicts.size(), r);
        if (!d.kind && d.peer_known && d.nonce_ok && d.packet_len >= nrf_pkg::MIN_LEN
            && d.auth_ok)
        begin
            used_prefix.insert(used_prefix.size(), d.nonce_prefix);
            used_counter.insert(used_counter.size(), d.nonce_counter);
            used_peer.insert(used_peer.size(), d.peer);
            if (used_prefix.size() > 32)
            begin
                used_prefix.delete(0);
                used_counter.delete(0);
                used_peer.delete(0);
            end
        end
        req.valid <= 1'b0;
        // ready drops after a take, since the filter leaves ST_IDLE
        @(posedge clk);
    endtask

    // A typed-in expectation replaces the predictor's entry for that request.
    task automatic send_checked(nrf_tb_pkg::pkt_desc_t d, bit typed,
                                nrf_tb_pkg::verdict_rec_t want);
        int last;
        send_request(d);
        last = pending_verdicts.size() - 1;
        if (typed)
        begin
            if (pending_verdicts[last] !== want)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row: predicted %0d/%h, table %0d/%h",
                             pending_verdicts[last].verdict,
                             pending_verdicts[last].packet_id,
                             want.verdict, want.packet_id);
            end
            pending_verdicts[last] = want;
        end
    endtask

    task automatic drain_all();
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    function automatic void add_row(nrf_tb_pkg::pkt_desc_t d, bit typed,
                                    nrf_tb_pkg::verdict_rec_t want);
        stim_row_t row;
        row.d     = d;
        row.typed = typed;
        row.want  = want;
        rows.insert(rows.size(), row);
    endfunction

    function automatic nrf_tb_pkg::pkt_desc_t random_packet();
        nrf_tb_pkg::pkt_desc_t d;
        int k;
        d.kind          = ($urandom_range(99) < 3);
        d.peer          = $urandom_range(3);
        d.packet_len    = ($urandom_range(99) < 5) ? 16'($urandom_range(6))
                                                   : 16'($urandom);
        d.peer_known    = ($urandom_range(99) < 94);
        d.nonce_ok      = ($urandom_range(99) < 94);
        d.nonce_prefix  = $urandom;
        d.nonce_counter = {$urandom, $urandom};
        d.auth_ok       = ($urandom_range(99) < 88);
        if (used_prefix.size() != 0 && $urandom_range(99) < 25)
        begin
            k = $urandom_range(used_prefix.size() - 1);
            d.nonce_prefix  = used_prefix[k];
            d.nonce_counter = used_counter[k];
            if ($urandom_range(3) != 0)
                d.peer = used_peer[k];
        end
        return d;
    endfunction

    // response side: stall and compare
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response %0d/%h", rsp.verdict, rsp.packet_id);
                end
                else
                begin
                    nrf_tb_pkg::verdict_rec_t want;
                    want = pending_verdicts[0];
                    pending_verdicts.delete(0);
                    if (rsp.verdict !== want.verdict || rsp.packet_id !== want.packet_id)
                    begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: verdict exp %0d got %0d, id exp %h got %h",
                                     want.verdict, rsp.verdict, want.packet_id,
                                     rsp.packet_id);
                    end
                end
            end
            rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        nrf_tb_pkg::pkt_desc_t d;
        logic [63:0] big_id;
        req.valid = 1'b0; req.kind = 1'b0; req.peer = '0; req.packet_len = '0;
        req.peer_known = 1'b0; req.nonce_ok = 1'b0; req.nonce_prefix = '0;
        req.nonce_counter = '0; req.auth_ok = 1'b0;
        rsp.ready = 1'b0;
        for (int p = 0; p < nrf_pkg::PEERS; p++)
        begin
            win_head[p] = 0;
            win_fill[p] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        big_id = mix_nonce(32'hffffffff, 64'hffffffffffffffff);
        // directed table
        add_row('{1'b0, 2'd0, 16'd0,    1'b1, 1'b1, 32'h0, 64'h0, 1'b1}, 1'b1,
                '{nrf_pkg::V_SHORT, 64'd0});
        add_row('{1'b0, 2'd1, 16'd4,    1'b1, 1'b1, '1, '1, 1'b1}, 1'b1,
                '{nrf_pkg::V_SHORT, 64'd0});
        add_row('{1'b0, 2'd2, 16'd5,    1'b0, 1'b1, '1, '1, 1'b1}, 1'b1,
                '{nrf_pkg::V_UNKNOWN, 64'd0});
        add_row('{1'b0, 2'd3, 16'hffff, 1'b1, 1'b0, '1, '1, 1'b1}, 1'b1,
                '{nrf_pkg::V_BADNONCE, 64'd0});
        add_row('{1'b0, 2'd0, 16'd5,    1'b1, 1'b1, 32'h0, 64'h0, 1'b1}, 1'b1,
                '{nrf_pkg::V_ACCEPT, 64'd0});
        add_row('{1'b0, 2'd0, 16'd64,   1'b1, 1'b1, 32'h0, 64'h0, 1'b1}, 1'b1,
                '{nrf_pkg::V_REPLAY, 64'd0});
        add_row('{1'b0, 2'd3, 16'hffff, 1'b1, 1'b1, '1, '1, 1'b0}, 1'b1,
                '{nrf_pkg::V_AUTHFAIL, big_id});
        add_row('{1'b0, 2'd3, 16'hffff, 1'b1, 1'b1, '1, '1, 1'b1}, 1'b1,
                '{nrf_pkg::V_ACCEPT, big_id});
        add_row('{1'b0, 2'd3, 16'd100,  1'b1, 1'b1, '1, '1, 1'b0}, 1'b1,
                '{nrf_pkg::V_REPLAY, big_id});
        add_row('{1'b0, 2'd1, 16'd9,    1'b1, 1'b1, '1, '1, 1'b1}, 1'b0,
                '{nrf_pkg::V_ACCEPT, 64'd0});
        add_row('{1'b1, 2'd3, 16'h0,    1'b0, 1'b0, '1, '1, 1'b0}, 1'b1,
                '{nrf_pkg::V_CLEARED, 64'd0});
        add_row('{1'b0, 2'd3, 16'd200,  1'b1, 1'b1, '1, '1, 1'b1}, 1'b1,
                '{nrf_pkg::V_ACCEPT, big_id});
        add_row('{1'b0, 2'd2, 16'd77,   1'b1, 1'b1, 32'h1234, 64'h5, 1'b1}, 1'b0,
                '{nrf_pkg::V_ACCEPT, 64'd0});
        add_row('{1'b1, 2'd0, 16'hffff, 1'b1, 1'b1, 32'h0, 64'h0, 1'b1}, 1'b1,
                '{nrf_pkg::V_CLEARED, 64'd0});
        add_row('{1'b0, 2'd0, 16'd6,    1'b1, 1'b1, 32'h0, 64'h0, 1'b1}, 1'b1,
                '{nrf_pkg::V_ACCEPT, 64'd0});
        foreach (rows[i])
            send_checked(rows[i].d, rows[i].typed, rows[i].want);
        drain_all();

        // short run on peer 1, then probes that are partly replays
        for (int n = 0; n < 16; n++)
        begin
            d = '{1'b0, 2'd1, 16'd64, 1'b1, 1'b1, 32'hA5A5_0000, 64'(n), 1'b1};
            send_request(d);
        end
        for (int n = 0; n < 12; n++)
        begin
            d = '{1'b0, 2'd1, 16'd64, 1'b1, 1'b1, 32'hA5A5_0000, 64'(n * 2), 1'b0};
            send_request(d);
        end
        drain_all();
        d = '{1'b1, 2'd1, 16'd0, 1'b0, 1'b0, 32'h0, 64'h0, 1'b0};
        send_request(d);

        // receiver holds off while requests keep coming
        fork
            begin
                recv_hold = 1'b1;
                repeat (400) @(posedge clk);
                recv_hold = 1'b0;
            end
            for (int n = 0; n < 20; n++)
                send_request(random_packet());
        join
        drain_all();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 85 : 0;
            recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 11 : 0;
            for (int n = 0; n < N_RANDOM / 3; n++)
                send_request(random_packet());
            drain_all();
        end
        recv_idle_pct = 0;
        repeat (nrf_pkg::WINDOW + 50) @(posedge clk);

        if (!failed && pending_verdicts.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
